>>> src/ipid_pkg.sv
package ipid_pkg;

	localparam int DATA_W = 16;
	localparam int ERR_W = DATA_W + 1;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_KP       = 3'd1,
		REG_KI       = 3'd2,
		REG_KD       = 3'd3,
		REG_EPSILON  = 3'd4
	} reg_idx_t;

	localparam logic signed [DATA_W-1:0] SETPOINT_RST = 16'sd300;
	localparam logic signed [DATA_W-1:0] GAIN_RST     = 16'sd256;
	localparam logic        [DATA_W-1:0] EPSILON_RST  = 16'd300;

	typedef struct packed {
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kd;
		logic        [DATA_W-1:0] epsilon;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic                    skip;
	} err_word_t;

endpackage

>>> src/ipid_if.sv
interface ipid_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ipid_pkg::DATA_W-1:0]   process_value;

	modport source (output valid, output process_value, input ready);
	modport sink (input valid, input process_value, output ready);
endinterface

interface ipid_out_if #(
	parameter int DRIVE_W = 11
);
	logic                       valid;
	logic                       ready;
	logic signed [DRIVE_W-1:0]  drive_value;
	logic                       integral_skipped;

	modport source (output valid, output drive_value, output integral_skipped, input ready);
	modport sink (input valid, input drive_value, input integral_skipped, output ready);
endinterface

>>> src/ipid_err.sv
module ipid_err (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipid_pkg::cfg_t        cfg,
	ipid_in_if.sink               in,
	input  logic                  take,
	output logic                  valid_s1,
	output ipid_pkg::err_word_t   word_s1
);

	logic signed [ipid_pkg::ERR_W-1:0] err;
	logic        [ipid_pkg::ERR_W-1:0] mag;
	logic                              load;

	assign err = ipid_pkg::ERR_W'(cfg.setpoint) - ipid_pkg::ERR_W'(in.process_value);
	assign mag = err[ipid_pkg::ERR_W-1] ? ipid_pkg::ERR_W'(-err) : ipid_pkg::ERR_W'(err);
	assign in.ready = !valid_s1 || take;
	assign load = in.valid && in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1.err <= err;
			word_s1.skip <= (mag <= {1'b0, cfg.epsilon});
		end
	end

endmodule

>>> src/ipid_acc.sv
module ipid_acc #(
	parameter int FRAC_BITS = 8,
	parameter int DRIVE_LIMIT = 1000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipid_pkg::cfg_t        cfg,
	input  logic                  valid_s1,
	input  ipid_pkg::err_word_t   word_s1,
	output logic                  take,
	ipid_out_if.source            out
);

	localparam int ERR_W = ipid_pkg::ERR_W;
	localparam int D1_W = ERR_W + 1;
	localparam int D2_W = ERR_W + 2;
	localparam int PI_W = ipid_pkg::DATA_W + ERR_W;
	localparam int PP_W = ipid_pkg::DATA_W + D1_W;
	localparam int PD_W = ipid_pkg::DATA_W + D2_W;
	localparam int SUM_W = PD_W + 4;
	localparam longint LIM_I = longint'(DRIVE_LIMIT) << FRAC_BITS;
	localparam longint FOLD_I = longint'(DRIVE_LIMIT / 2) << FRAC_BITS;
	localparam int ACC_W = $clog2(LIM_I + 1) + 1;
	localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1;
	localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(LIM_I);
	localparam logic signed [SUM_W-1:0] LIM_NEG = SUM_W'(-LIM_I);
	localparam logic signed [ACC_W-1:0] FOLD_POS = ACC_W'(FOLD_I);
	localparam logic signed [ACC_W-1:0] FOLD_NEG = ACC_W'(-FOLD_I);

	logic signed [ERR_W-1:0]  last_q;
	logic signed [ERR_W-1:0]  prior_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                     skip_q;

	logic signed [D1_W-1:0]   d1;
	logic signed [D2_W-1:0]   d2;
	logic signed [PP_W-1:0]   pp;
	logic signed [PI_W-1:0]   pi;
	logic signed [PD_W-1:0]   pd;
	logic signed [SUM_W-1:0]  inc;
	logic signed [SUM_W-1:0]  nxt;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  acc_sh;

	assign d1 = D1_W'(word_s1.err) - D1_W'(last_q);
	assign d2 = D2_W'(word_s1.err) - (D2_W'(last_q) <<< 1) + D2_W'(prior_q);
	assign pp = PP_W'(cfg.kp) * PP_W'(d1);
	assign pi = PI_W'(cfg.ki) * PI_W'(word_s1.err);
	assign pd = PD_W'(cfg.kd) * PD_W'(d2);

	always_comb begin
		inc = SUM_W'(pp) + SUM_W'(pd);
		if (!word_s1.skip) begin
			inc = inc + SUM_W'(pi);
		end
		nxt = SUM_W'(acc_q) + inc;
		priority if (nxt > LIM_POS) begin
			acc_d = FOLD_POS;
		end else if (nxt < LIM_NEG) begin
			acc_d = FOLD_NEG;
		end else begin
			acc_d = ACC_W'(nxt);
		end
	end

	assign acc_sh = acc_d >>> FRAC_BITS;
	assign take = valid_s1 && (!out_valid_q || out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			prior_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				last_q <= word_s1.err;
				prior_q <= last_q;
				acc_q <= acc_d;
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			drive_q <= DRIVE_W'(acc_sh);
			skip_q <= word_s1.skip;
		end
	end

	assign out.valid = out_valid_q;
	assign out.drive_value = drive_q;
	assign out.integral_skipped = skip_q;

endmodule

>>> src/incremental_pid_integral_separation.sv
// Velocity-form PID with integral separation. Each input word carries one
// measured value; each produces exactly one output word holding the integer
// part of the fixed-point drive accumulator (FRAC_BITS fraction bits) and a
// flag telling whether the integral term was dropped because |error| was at
// or below epsilon. The accumulator folds to +/-DRIVE_LIMIT/2 when it leaves
// +/-DRIVE_LIMIT. A new word is taken every cycle unless the output stalls:
// one input register holds the error; the three gain products, their sum and
// the fold settle combinationally into the result register. The user must
// write gains and setpoint via the cfg port (index 0 setpoint, 1 kp, 2 ki,
// 3 kd, 4 epsilon) only while no word is in flight, unenforced by the block.
module incremental_pid_integral_separation #(
	parameter int FRAC_BITS = 8,
	parameter int DRIVE_LIMIT = 1000
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipid_pkg::DATA_W-1:0]       cfg_data,
	ipid_in_if.sink                           in,
	ipid_out_if.source                        out
);

	ipid_pkg::cfg_t      cfg_q;
	ipid_pkg::err_word_t word_s1;
	logic                valid_s1;
	logic                take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= ipid_pkg::SETPOINT_RST;
			cfg_q.kp <= ipid_pkg::GAIN_RST;
			cfg_q.ki <= ipid_pkg::GAIN_RST;
			cfg_q.kd <= ipid_pkg::GAIN_RST;
			cfg_q.epsilon <= ipid_pkg::EPSILON_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipid_pkg::REG_SETPOINT: cfg_q.setpoint <= cfg_data;
				ipid_pkg::REG_KP:       cfg_q.kp <= cfg_data;
				ipid_pkg::REG_KI:       cfg_q.ki <= cfg_data;
				ipid_pkg::REG_KD:       cfg_q.kd <= cfg_data;
				ipid_pkg::REG_EPSILON:  cfg_q.epsilon <= cfg_data;
				default: ;
			endcase
		end
	end

	ipid_err u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in       (in),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	ipid_acc #(
		.FRAC_BITS   (FRAC_BITS),
		.DRIVE_LIMIT (DRIVE_LIMIT)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.take     (take),
		.out      (out)
	);

endmodule

>>> src/ipid_chk.sv
module ipid_chk #(
	parameter int DRIVE_LIMIT = 1000,
	parameter int DRIVE_W = 11
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [DRIVE_W-1:0]  drive_value,
	input logic                       integral_skipped
);

	localparam logic signed [DRIVE_W-1:0] LIM_POS = DRIVE_W'(DRIVE_LIMIT);
	localparam logic signed [DRIVE_W-1:0] LIM_NEG = DRIVE_W'(-DRIVE_LIMIT);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_value)
			&& $stable(integral_skipped))
		else $error("output word changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_value <= LIM_POS && drive_value >= LIM_NEG)
		else $error("drive value outside fold limits");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted word did not reach the output");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

endmodule

bind incremental_pid_integral_separation ipid_chk #(
	.DRIVE_LIMIT (DRIVE_LIMIT),
	.DRIVE_W     ($clog2(DRIVE_LIMIT + 1) + 1)
) u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in.valid),
	.in_ready         (in.ready),
	.out_valid        (out.valid),
	.out_ready        (out.ready),
	.drive_value      (out.drive_value),
	.integral_skipped (out.integral_skipped)
);
